FILE: hdl/cebl_pkg.sv
package cebl_pkg;

  localparam int CHANNEL_BITS = 16;
  localparam logic [CHANNEL_BITS-1:0] CH_MAX = '1;
  localparam logic [CHANNEL_BITS-1:0] HALF_MAX = CH_MAX >> 1;

  // One long division in flight: partial remainder, divisor, the numerator
  // bits still to be brought down (MSB first) and the quotient built so far.
  typedef struct packed {
    logic [CHANNEL_BITS-1:0] rem;
    logic [CHANNEL_BITS-1:0] den;
    logic [CHANNEL_BITS:0]   nlo;
    logic [CHANNEL_BITS:0]   quo;
    logic                    skip;
  } lane_t;

  typedef struct packed {
    logic                          valid;
    lane_t [2:0]                   lane;
    logic [3:0][CHANNEL_BITS-1:0]  bot;
    logic [3:0][CHANNEL_BITS-1:0]  top;
    logic [CHANNEL_BITS-1:0]       a;
    logic [2*CHANNEL_BITS-1:0]     aux;
    logic                          azero;
  } pipe_t;

  // Division by 2^N - 1 using x = q0 * 2^N + lo = q0 * M + (q0 + lo).
  function automatic logic [CHANNEL_BITS:0] div_by_max(
    input logic [2*CHANNEL_BITS-1:0] x
  );
    logic [CHANNEL_BITS:0] q;
    logic [CHANNEL_BITS:0] r;
    q = {1'b0, x[2*CHANNEL_BITS-1:CHANNEL_BITS]};
    r = {1'b0, x[CHANNEL_BITS-1:0]} + {1'b0, x[2*CHANNEL_BITS-1:CHANNEL_BITS]};
    if (r >= {1'b0, CH_MAX}) begin
      q = q + 1'b1;
      r = r - {1'b0, CH_MAX};
    end
    if (r >= {1'b0, CH_MAX}) begin
      q = q + 1'b1;
    end
    return q;
  endfunction

endpackage

FILE: hdl/cebl_div_cell.sv
module cebl_div_cell import cebl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  pipe_t d,
  output pipe_t q
);

  pipe_t nxt;

  // One restoring division step on each of the three lanes.
  always_comb begin
    logic [CHANNEL_BITS:0] t;
    logic                  ge;
    nxt = d;
    for (int c = 0; c < 3; c++) begin
      t  = {d.lane[c].rem, d.lane[c].nlo[CHANNEL_BITS]};
      ge = t >= {1'b0, d.lane[c].den};
      if (ge) begin
        t = t - {1'b0, d.lane[c].den};
      end
      nxt.lane[c].rem = t[CHANNEL_BITS-1:0];
      nxt.lane[c].nlo = {d.lane[c].nlo[CHANNEL_BITS-1:0], 1'b0};
      nxt.lane[c].quo = {d.lane[c].quo[CHANNEL_BITS-1:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= nxt;
    end
  end

endmodule

FILE: hdl/colour_erase_blend_unit.sv
// Channel  | Direction | Transfer when        | Payload
// input    | in        | in_valid & in_ready  | bottom_*, top_* (RGBA)
// output   | out       | out_valid & out_ready| out_* (RGBA)
//
// One pixel per cycle is accepted while the pipeline is not stalled.
// The pipeline holds two chains of division cells, one quotient bit
// per cell: CHANNEL_BITS cells for the alpha and CHANNEL_BITS+1 for colour.
// Reset is synchronous and clears only the valid bits of the pipeline.
// The whole pipeline stalls when the output register is full and not taken.
module colour_erase_blend_unit import cebl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CHANNEL_BITS-1:0] bottom_red,
  input  logic [CHANNEL_BITS-1:0] bottom_green,
  input  logic [CHANNEL_BITS-1:0] bottom_blue,
  input  logic [CHANNEL_BITS-1:0] bottom_opacity,
  input  logic [CHANNEL_BITS-1:0] top_red,
  input  logic [CHANNEL_BITS-1:0] top_green,
  input  logic [CHANNEL_BITS-1:0] top_blue,
  input  logic [CHANNEL_BITS-1:0] top_opacity,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CHANNEL_BITS-1:0] out_red,
  output logic [CHANNEL_BITS-1:0] out_green,
  output logic [CHANNEL_BITS-1:0] out_blue,
  output logic [CHANNEL_BITS-1:0] out_opacity
);

  localparam int W = CHANNEL_BITS;

  logic  adv;
  pipe_t p0;
  pipe_t ach [W+1];
  pipe_t pm;
  pipe_t stm;
  pipe_t pt;
  pipe_t stt;
  pipe_t pc;
  pipe_t cch [W+2];
  logic [3:0][W-1:0] res;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Alpha proposals: numerator |b - t| * M + den / 2 for each colour channel.
  always_comb begin
    logic            lt;
    logic [W-1:0]    diff;
    logic [W-1:0]    den;
    logic [2*W-1:0]  num;
    p0       = '0;
    p0.valid = in_valid;
    p0.bot   = {bottom_opacity, bottom_blue, bottom_green, bottom_red};
    p0.top   = {top_opacity, top_blue, top_green, top_red};
    for (int c = 0; c < 3; c++) begin
      lt   = p0.bot[c] < p0.top[c];
      diff = lt ? p0.top[c] - p0.bot[c] : p0.bot[c] - p0.top[c];
      den  = lt ? p0.top[c] : CH_MAX - p0.top[c];
      num  = {diff, {W{1'b0}}} - {{W{1'b0}}, diff} + {{(W+1){1'b0}}, den[W-1:1]};
      p0.lane[c].rem  = num[2*W-1:W];
      p0.lane[c].nlo  = {num[W-1:0], 1'b0};
      p0.lane[c].den  = den;
      p0.lane[c].quo  = '0;
      p0.lane[c].skip = !lt && (p0.top[c] == CH_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ach[0].valid <= 1'b0;
    end else if (adv) begin
      ach[0] <= p0;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_alpha
    cebl_div_cell u_cell (.clk(clk), .rst(rst), .en(adv), .d(ach[k]), .q(ach[k+1]));
  end

  // Largest proposal, then the product for the top opacity blend.
  always_comb begin
    logic [W-1:0] alpha;
    pm    = ach[W];
    alpha = '0;
    for (int c = 0; c < 3; c++) begin
      if (!ach[W].lane[c].skip && ach[W].lane[c].quo[W-1:0] > alpha) begin
        alpha = ach[W].lane[c].quo[W-1:0];
      end
    end
    pm.aux = {{W{1'b0}}, CH_MAX - alpha} * {{W{1'b0}}, ach[W].top[3]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stm.valid <= 1'b0;
    end else if (adv) begin
      stm <= pm;
    end
  end

  always_comb begin
    logic [W:0] tq;
    pt   = stm;
    tq   = div_by_max(stm.aux + {{W{1'b0}}, HALF_MAX});
    pt.a = CH_MAX - tq[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stt.valid <= 1'b0;
    end else if (adv) begin
      stt <= pt;
    end
  end

  // Colour quotients need W+1 bits; a larger quotient only saturates.
  always_comb begin
    logic [W-1:0]   diff;
    logic [2*W-1:0] num;
    logic [W-2:0]   hi;
    logic           ovf;
    pc       = stt;
    pc.azero = stt.a == '0;
    pc.aux   = {{W{1'b0}}, stt.a} * {{W{1'b0}}, stt.bot[3]};
    for (int c = 0; c < 3; c++) begin
      diff = (stt.bot[c] >= stt.top[c]) ? stt.bot[c] - stt.top[c]
                                        : stt.top[c] - stt.bot[c];
      num  = {diff, {W{1'b0}}} - {{W{1'b0}}, diff}
           + {{(W+1){1'b0}}, stt.a[W-1:1]};
      hi   = num[2*W-1:W+1];
      ovf  = {1'b0, hi} >= stt.a;
      pc.lane[c].rem  = ovf ? '0 : {1'b0, hi};
      pc.lane[c].nlo  = num[W:0];
      pc.lane[c].den  = stt.a;
      pc.lane[c].quo  = '0;
      pc.lane[c].skip = ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cch[0].valid <= 1'b0;
    end else if (adv) begin
      cch[0] <= pc;
    end
  end

  for (genvar k = 0; k < W+1; k++) begin : g_colour
    cebl_div_cell u_cell (.clk(clk), .rst(rst), .en(adv), .d(cch[k]), .q(cch[k+1]));
  end

  always_comb begin
    logic [W:0]   q;
    logic [W+1:0] sum;
    logic [W:0]   oq;
    for (int c = 0; c < 3; c++) begin
      q   = cch[W+1].lane[c].quo;
      sum = {2'b00, cch[W+1].top[c]} + {1'b0, q};
      if (cch[W+1].azero) begin
        res[c] = cch[W+1].bot[c];
      end else if (cch[W+1].bot[c] >= cch[W+1].top[c]) begin
        res[c] = (cch[W+1].lane[c].skip || sum > {2'b00, CH_MAX}) ? CH_MAX
                                                                  : sum[W-1:0];
      end else begin
        res[c] = (cch[W+1].lane[c].skip || q >= {1'b0, cch[W+1].top[c]}) ? '0
               : cch[W+1].top[c] - q[W-1:0];
      end
    end
    oq     = div_by_max(cch[W+1].aux + {{W{1'b0}}, HALF_MAX});
    res[3] = oq[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid   <= cch[W+1].valid;
      out_red     <= res[0];
      out_green   <= res[1];
      out_blue    <= res[2];
      out_opacity <= res[3];
    end
  end

  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the output stage");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_zero_alpha_ovf: assert property (@(posedge clk) disable iff (rst)
    (cch[0].valid && cch[0].azero) |->
      (cch[0].lane[0].skip && cch[0].lane[1].skip && cch[0].lane[2].skip))
    else $error("zero alpha did not mark every colour lane");

endmodule
